// ----- src/sdspi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_pkg
// types, codes and crc helper for the sd card spi host sequencer
// ----------------------------------------------------------------------------
package sdspi_pkg;

  typedef enum logic [1:0] {
    OP_EXCHANGE = 2'd0,
    OP_INIT     = 2'd1,
    OP_WRITE    = 2'd2,
    OP_RSVD     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_IF_COND  = 2'd0,
    REG_OP_COND  = 2'd1,
    REG_IDLE_ATT = 2'd2,
    REG_RDY_ATT  = 2'd3
  } reg_e;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_IDLE   = 3'd1;
  localparam logic [2:0] ST_BAD_IFC   = 3'd2;
  localparam logic [2:0] ST_INIT_TO   = 3'd3;
  localparam logic [2:0] ST_WR_REFUSE = 3'd4;
  localparam logic [2:0] ST_NO_DRESP  = 3'd5;
  localparam logic [2:0] ST_BUSY_TO   = 3'd6;

  localparam logic [5:0] CMD_GO_IDLE = 6'd0;
  localparam logic [5:0] CMD_IF_COND = 6'd8;
  localparam logic [5:0] CMD_WRITE   = 6'd24;
  localparam logic [5:0] CMD_OP_COND = 6'd41;
  localparam logic [5:0] CMD_APP     = 6'd55;
  localparam logic [5:0] CMD_READ_OCR = 6'd58;

  localparam logic [7:0] BYTE_FILL  = 8'hFF;
  localparam logic [7:0] TOKEN_START = 8'hFE;
  localparam logic [7:0] R1_IDLE    = 8'h01;
  localparam logic [4:0] DRESP_OK   = 5'h05;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  miso_byte;
    logic [7:0]  write_byte;
    logic [31:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  mosi_byte;
    logic        card_selected;
    logic        byte_valid;
    logic        need_data;
    logic        done_res;
    logic [2:0]  status;
    logic [7:0]  r1_value;
    logic [31:0] ocr_value;
  } out_item_t;

  typedef struct packed {
    logic [11:0] if_cond;
    logic [31:0] op_cond;
    logic [7:0]  idle_att;
    logic [7:0]  rdy_att;
  } cfg_t;

  function automatic logic [6:0] crc7_byte(logic [6:0] crc, logic [7:0] b);
    logic [6:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[6] ^ b[i];
      c  = {c[5:0], 1'b0};
      if (fb) c = c ^ 7'h09;
    end
    return c;
  endfunction

endpackage

// ----- src/sd_card_spi_host_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_card_spi_host_sequencer
// sd card spi host: init sequence and single block write
// ----------------------------------------------------------------------------
// channel   direction  handshake        payload
// in        input      in_valid/stall   in_item_t
// out       output     out_valid/stall  out_item_t
// cfg       input      cfg_valid/ready  index, data
//
// one item per cycle sustained while neither side stalls; a result item passes
// through the input register, the queue and the result register, in that order.
// the back decides each byte combinationally and registers it.
// reset returns to idle with default registers. either side may stall,
// the queue absorbs the difference. cfg writes are always taken.
module sd_card_spi_host_sequencer #(
  parameter int unsigned InitFillBytes  = 10,
  parameter int unsigned BlockBytes     = 512,
  parameter int unsigned ResponsePolls  = 9,
  parameter int unsigned WritePollLimit = 3907,
  parameter int unsigned PreCmdPolls    = 2002
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sdspi_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sdspi_pkg::out_item_t out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  sdspi_pkg::cfg_t     cfg_q;
  sdspi_pkg::in_item_t f_data, q_data;
  logic                push, full, pop, avail;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{if_cond: 12'd426, op_cond: 32'h4000_0000, idle_att: 8'd100, rdy_att: 8'd100};
    end else if (cfg_valid_i) begin
      unique case (sdspi_pkg::reg_e'(cfg_index_i))
        sdspi_pkg::REG_IF_COND:  cfg_q.if_cond  <= cfg_data_i[11:0];
        sdspi_pkg::REG_OP_COND:  cfg_q.op_cond  <= cfg_data_i;
        sdspi_pkg::REG_IDLE_ATT: cfg_q.idle_att <= cfg_data_i[7:0];
        sdspi_pkg::REG_RDY_ATT:  cfg_q.rdy_att  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  sdspi_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .q_full_i(full), .q_push_o(push), .q_data_o(f_data)
  );

  sdspi_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(f_data), .full_o(full),
    .pop_i(pop), .avail_o(avail), .data_o(q_data)
  );

  sdspi_back #(
    .InitFillBytes(InitFillBytes), .BlockBytes(BlockBytes),
    .ResponsePolls(ResponsePolls), .WritePollLimit(WritePollLimit),
    .PreCmdPolls(PreCmdPolls)
  ) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .q_avail_i(avail), .q_data_i(q_data),
    .q_pop_o(pop), .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

// ----- src/sdspi_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_queue
// two-entry item queue between the front and the back
// ----------------------------------------------------------------------------
module sdspi_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sdspi_pkg::in_item_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                avail_o,
  output sdspi_pkg::in_item_t data_o
);

  sdspi_pkg::in_item_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign avail_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// ----- src/sdspi_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_front
// input stage: registers items and folds reserved operation into exchange
// ----------------------------------------------------------------------------
module sdspi_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sdspi_pkg::in_item_t in_data_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output sdspi_pkg::in_item_t q_data_o
);

  logic                valid_q;
  sdspi_pkg::in_item_t item_q;
  sdspi_pkg::in_item_t item_d;
  logic                take;

  assign q_push_o   = valid_q && !q_full_i;
  assign in_stall_o = valid_q && q_full_i;
  assign take       = in_valid_i && !in_stall_o;
  assign q_data_o   = item_q;

  always_comb begin
    item_d = in_data_i;
    // reserved code behaves as exchange
    if (in_data_i.operation == sdspi_pkg::OP_RSVD) item_d.operation = sdspi_pkg::OP_EXCHANGE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (q_push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

// ----- src/sdspi_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_back
// protocol sequencer: unless the output stalls or the queue is empty, one queued item in, one result item out per cycle
// ----------------------------------------------------------------------------
module sdspi_back #(
  parameter int unsigned InitFillBytes  = 10,
  parameter int unsigned BlockBytes     = 512,
  parameter int unsigned ResponsePolls  = 9,
  parameter int unsigned WritePollLimit = 3907,
  parameter int unsigned PreCmdPolls    = 2002
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sdspi_pkg::cfg_t      cfg_i,
  input  logic                 q_avail_i,
  input  sdspi_pkg::in_item_t  q_data_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sdspi_pkg::out_item_t out_data_o
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_DONE, PH_FILL, PH_PRE, PH_SEL, PH_CLEAR, PH_CMD, PH_R1,
    PH_EXTRA, PH_TOKEN, PH_DATA, PH_DRESP, PH_BUSY, PH_POST, PH_LAST
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [9:0]  byte_q, byte_d;
  logic [11:0] poll_q, poll_d;
  logic [7:0]  att_q, att_d;
  logic [31:0] shift_q, shift_d;
  logic [7:0]  r1_q, r1_d;
  logic [31:0] addr_q, addr_d;
  logic [5:0]  cmd_q, cmd_d;
  logic [2:0]  stat_q, stat_d;
  logic [31:0] ocr_q, ocr_d;
  logic [7:0]  crc_q;
  logic        out_valid_q;
  sdspi_pkg::out_item_t out_q;

  logic [7:0]  o_byte;
  logic        o_sel, o_val, o_need;
  logic        step;
  logic [31:0] arg;
  logic [7:0]  cb;
  logic [6:0]  crc_acc;
  logic [7:0]  miso, wb;

  assign step        = q_avail_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o     = step;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign miso        = q_data_i.miso_byte;
  assign wb          = q_data_i.write_byte;

  always_comb begin
    unique case (cmd_q)
      sdspi_pkg::CMD_IF_COND: arg = {20'd0, cfg_i.if_cond};
      sdspi_pkg::CMD_OP_COND: arg = cfg_i.op_cond;
      sdspi_pkg::CMD_WRITE:   arg = addr_q;
      default:                arg = 32'd0;
    endcase
  end

  // crc of the five header bytes of the current command, all bytes in one combinational pass
  always_comb begin
    crc_acc = sdspi_pkg::crc7_byte(7'd0, {2'b01, cmd_q});
    crc_acc = sdspi_pkg::crc7_byte(crc_acc, arg[31:24]);
    crc_acc = sdspi_pkg::crc7_byte(crc_acc, arg[23:16]);
    crc_acc = sdspi_pkg::crc7_byte(crc_acc, arg[15:8]);
    crc_acc = sdspi_pkg::crc7_byte(crc_acc, arg[7:0]);
  end

  always_ff @(posedge clk_i) crc_q <= {crc_acc, 1'b1};

  always_comb begin
    unique case (byte_q[2:0])
      3'd1:    cb = arg[31:24];
      3'd2:    cb = arg[23:16];
      3'd3:    cb = arg[15:8];
      3'd4:    cb = arg[7:0];
      default: cb = crc_q;
    endcase
  end

  always_comb begin
    phase_d = phase_q; byte_d = byte_q; poll_d = poll_q; att_d = att_q;
    shift_d = shift_q; r1_d = r1_q; addr_d = addr_q; cmd_d = cmd_q;
    stat_d = stat_q; ocr_d = ocr_q;
    o_byte = sdspi_pkg::BYTE_FILL; o_sel = 1'b0; o_val = 1'b0; o_need = 1'b0;

    unique case (sdspi_pkg::op_e'(q_data_i.operation))
      sdspi_pkg::OP_INIT: begin
        ocr_d = '0; stat_d = sdspi_pkg::ST_OK; att_d = '0; byte_d = 10'd1;
        phase_d = PH_FILL; o_val = 1'b1;
      end
      sdspi_pkg::OP_WRITE: begin
        addr_d = q_data_i.block_address; stat_d = sdspi_pkg::ST_OK;
        cmd_d = sdspi_pkg::CMD_WRITE; o_val = 1'b1; phase_d = PH_PRE;
      end
      default: begin
        unique case (phase_q)
          PH_FILL: begin
            o_val = 1'b1;
            if (byte_q < 10'(InitFillBytes + 1)) byte_d = byte_q + 10'd1;
            else begin cmd_d = sdspi_pkg::CMD_GO_IDLE; phase_d = PH_PRE; end
          end
          PH_PRE: begin
            o_val = 1'b1; o_sel = 1'b1; phase_d = PH_SEL;
          end
          PH_SEL: begin
            o_val = 1'b1; o_sel = 1'b1;
            if (cmd_q == sdspi_pkg::CMD_READ_OCR && miso != sdspi_pkg::BYTE_FILL) begin
              poll_d = 12'd1; phase_d = PH_CLEAR;
            end else begin
              o_byte = {2'b01, cmd_q}; byte_d = 10'd1; phase_d = PH_CMD;
            end
          end
          PH_CLEAR: begin
            o_val = 1'b1; o_sel = 1'b1;
            if (miso == sdspi_pkg::BYTE_FILL || poll_q >= 12'(PreCmdPolls)) begin
              o_byte = {2'b01, cmd_q}; byte_d = 10'd1; phase_d = PH_CMD;
            end else poll_d = poll_q + 12'd1;
          end
          PH_CMD: begin
            o_val = 1'b1; o_sel = 1'b1;
            if (byte_q < 10'd6) begin o_byte = cb; byte_d = byte_q + 10'd1; end
            else begin poll_d = 12'd1; phase_d = PH_R1; end
          end
          PH_R1: begin
            o_val = 1'b1; o_sel = 1'b1;
            if (miso != sdspi_pkg::BYTE_FILL || poll_q >= 12'(ResponsePolls)) begin
              r1_d = miso;
              if ((cmd_q == sdspi_pkg::CMD_IF_COND || cmd_q == sdspi_pkg::CMD_READ_OCR)
                  && miso <= 8'd1) begin
                shift_d = '0; byte_d = 10'd1; phase_d = PH_EXTRA;
              end else if (cmd_q == sdspi_pkg::CMD_WRITE && miso == 8'd0) begin
                o_byte = sdspi_pkg::TOKEN_START; o_need = 1'b1; phase_d = PH_TOKEN;
              end else begin
                if (cmd_q == sdspi_pkg::CMD_WRITE) stat_d = sdspi_pkg::ST_WR_REFUSE;
                phase_d = PH_POST;
              end
            end else poll_d = poll_q + 12'd1;
          end
          PH_EXTRA: begin
            o_val = 1'b1; o_sel = 1'b1;
            shift_d = {shift_q[23:0], miso};
            if (byte_q < 10'd4) byte_d = byte_q + 10'd1;
            else phase_d = PH_POST;
          end
          PH_TOKEN: begin
            o_val = 1'b1; o_sel = 1'b1; o_byte = wb; byte_d = 10'd1;
            o_need = (1 < BlockBytes); phase_d = PH_DATA;
          end
          PH_DATA: begin
            o_val = 1'b1; o_sel = 1'b1;
            if (byte_q < 10'(BlockBytes)) begin
              o_byte = wb; byte_d = byte_q + 10'd1;
              o_need = (byte_q + 10'd1) < 10'(BlockBytes);
            end else begin poll_d = 12'd1; phase_d = PH_DRESP; end
          end
          PH_DRESP: begin
            o_val = 1'b1; o_sel = 1'b1;
            if (miso != sdspi_pkg::BYTE_FILL) begin
              if (miso[4:0] == sdspi_pkg::DRESP_OK) begin poll_d = 12'd1; phase_d = PH_BUSY; end
              else begin stat_d = sdspi_pkg::ST_NO_DRESP; phase_d = PH_POST; end
            end else if (poll_q >= 12'(WritePollLimit - 1)) begin
              stat_d = sdspi_pkg::ST_NO_DRESP; phase_d = PH_POST;
            end else poll_d = poll_q + 12'd1;
          end
          PH_BUSY: begin
            o_val = 1'b1; o_sel = 1'b1;
            if (miso != 8'd0) begin stat_d = sdspi_pkg::ST_OK; phase_d = PH_POST; end
            else if (poll_q >= 12'(WritePollLimit)) begin
              stat_d = sdspi_pkg::ST_BUSY_TO; phase_d = PH_POST;
            end else poll_d = poll_q + 12'd1;
          end
          PH_POST: begin
            o_val = 1'b1; phase_d = PH_LAST;
          end
          PH_LAST: begin
            // decide the next command from the latched response
            unique case (cmd_q)
              sdspi_pkg::CMD_GO_IDLE: begin
                if (r1_q == sdspi_pkg::R1_IDLE) begin
                  cmd_d = sdspi_pkg::CMD_IF_COND; o_val = 1'b1; phase_d = PH_PRE;
                end else if (att_q >= cfg_i.idle_att) begin
                  stat_d = sdspi_pkg::ST_NO_IDLE; phase_d = PH_DONE;
                end else begin
                  att_d = att_q + 8'd1; o_val = 1'b1; phase_d = PH_PRE;
                end
              end
              sdspi_pkg::CMD_IF_COND: begin
                if (r1_q == sdspi_pkg::R1_IDLE && shift_q[7:0] == cfg_i.if_cond[7:0]) begin
                  att_d = '0;
                  if (cfg_i.rdy_att == 8'd0) begin
                    stat_d = sdspi_pkg::ST_INIT_TO; phase_d = PH_DONE;
                  end else begin
                    cmd_d = sdspi_pkg::CMD_APP; o_val = 1'b1; phase_d = PH_PRE;
                  end
                end else begin
                  stat_d = sdspi_pkg::ST_BAD_IFC; phase_d = PH_DONE;
                end
              end
              sdspi_pkg::CMD_APP, sdspi_pkg::CMD_OP_COND: begin
                if (cmd_q == sdspi_pkg::CMD_APP && r1_q < 8'd2) begin
                  cmd_d = sdspi_pkg::CMD_OP_COND; o_val = 1'b1; phase_d = PH_PRE;
                end else if (cmd_q == sdspi_pkg::CMD_OP_COND && r1_q == 8'd0) begin
                  att_d = att_q + 8'd1;
                  cmd_d = sdspi_pkg::CMD_READ_OCR; o_val = 1'b1; phase_d = PH_PRE;
                end else begin
                  att_d = att_q + 8'd1;
                  if (att_q + 8'd1 >= cfg_i.rdy_att) begin
                    stat_d = sdspi_pkg::ST_INIT_TO; phase_d = PH_DONE;
                  end else begin
                    cmd_d = sdspi_pkg::CMD_APP; o_val = 1'b1; phase_d = PH_PRE;
                  end
                end
              end
              sdspi_pkg::CMD_READ_OCR: begin
                ocr_d = (r1_q <= 8'd1) ? shift_q : 32'd0;
                stat_d = sdspi_pkg::ST_OK; phase_d = PH_DONE;
              end
              default: phase_d = PH_DONE;
            endcase
          end
          default: ;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; byte_q <= '0; poll_q <= '0; att_q <= '0;
      shift_q <= '0; r1_q <= 8'hFF; addr_q <= '0; cmd_q <= '0;
      stat_q <= '0; ocr_q <= '0; out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (step) begin
        phase_q <= phase_d; byte_q <= byte_d; poll_q <= poll_d; att_q <= att_d;
        shift_q <= shift_d; r1_q <= r1_d; addr_q <= addr_d; cmd_q <= cmd_d;
        stat_q <= stat_d; ocr_q <= ocr_d; out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q.mosi_byte     <= o_byte;
      out_q.card_selected <= o_sel;
      out_q.byte_valid    <= o_val;
      out_q.need_data     <= o_need;
      out_q.done_res      <= (phase_d == PH_DONE);
      out_q.status        <= (phase_d == PH_DONE) ? stat_d : 3'd0;
      out_q.r1_value      <= r1_d;
      out_q.ocr_value     <= ocr_d;
    end
  end

endmodule

// ----- src/sdspi_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_checker
// port-level checks for the sd card spi host sequencer
// ----------------------------------------------------------------------------
module sdspi_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input sdspi_pkg::out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled item changed");

  a_idle_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |->
      out_data_o.mosi_byte == 8'hFF && !out_data_o.card_selected)
    else $error("no transfer but byte not idle");

  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.done_res |-> out_data_o.status == 3'd0)
    else $error("status without done");

  a_need_sel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.need_data |-> out_data_o.card_selected)
    else $error("data request while deselected");

endmodule

bind sd_card_spi_host_sequencer sdspi_checker u_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .out_data_o
);
